>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk in scope; DEQ_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Command and status codes and the control word broadcast to the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // At most one of these is set in a cycle.
    typedef struct packed {
        logic push_back;
        logic push_front;
        logic pop_front;
        logic pop_back;
        logic clear;
    } deq_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue row. Holds a word and an occupied flag and trades
// them with its neighbors on front pushes and pops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
    import deq_pkg::*;
#(
    parameter int DATA_WIDTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire deq_ctl_t              ctl,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] prev_data,
    input  wire logic                  prev_occ,
    input  wire logic [DATA_WIDTH-1:0] next_data,
    input  wire logic                  next_occ,
    output logic      [DATA_WIDTH-1:0] data,
    output logic                       occ
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occ_reg;
    logic                  occ_next;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctl.push_front)
        begin
            data_next = prev_data;
            occ_next  = prev_occ;
        end
        else if (ctl.push_back)
        begin
            // first free slot takes the word
            if (!occ_reg && prev_occ)
            begin
                data_next = value;
                occ_next  = 1'b1;
            end
        end
        else if (ctl.pop_front)
        begin
            data_next = next_data;
            occ_next  = next_occ;
        end
        else if (ctl.pop_back)
        begin
            if (occ_reg && !next_occ)
            begin
                occ_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

`default_nettype wire

>>> rtl/core/deq_back_sel.sv
// ----------------------------------------------------------------------------
// deq_back_sel
// Picks the word of the last occupied cell; zero when the row is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_back_sel #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8
) (
    input  wire logic [DEPTH-1:0]      occ,
    input  wire logic [DATA_WIDTH-1:0] data [DEPTH],
    output logic      [DATA_WIDTH-1:0] back_value
);

    logic [DEPTH-1:0] last;

    // occupancy is a thermometer from cell 0, so the tail is where it ends
    assign last[DEPTH-1]   = occ[DEPTH-1];
    assign last[DEPTH-2:0] = occ[DEPTH-2:0] & ~occ[DEPTH-1:1];

    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_value = back_value | (data[i] & {DATA_WIDTH{last[i]}});
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of DEPTH words. When a command is taken, the
// row of cells (cell 0 is the front) shifts or fills in that edge, and the
// result word is shown from the next cycle on until it is taken. in_stall is
// high while a result waits, so no new command is taken until it is. Front and
// count come straight from registers; the back word is selected from the cell
// marking the end of the occupied run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [CMD_W-1:0]             cmd,
    input  wire logic [DATA_WIDTH-1:0]        value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [STATUS_W-1:0]          status,
    output logic      [DATA_WIDTH-1:0]        front_value,
    output logic      [DATA_WIDTH-1:0]        back_value,
    output logic      [$clog2(DEPTH + 1)-1:0] count,
    output logic                              is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    deq_ctl_t              ctl;
    logic                  accept;
    logic                  full;
    logic                  empty;

    logic [DEPTH-1:0]      occ;
    logic [DATA_WIDTH-1:0] data      [DEPTH];
    logic [DATA_WIDTH-1:0] prev_data [DEPTH];
    logic [DATA_WIDTH-1:0] next_data [DEPTH];
    logic [DEPTH-1:0]      prev_occ;
    logic [DEPTH-1:0]      next_occ;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign full     = occ[DEPTH-1];
    assign empty    = !occ[0];

    always_comb
    begin
        ctl         = '0;
        status_next = status_reg;
        count_next  = count_reg;
        if (accept)
        begin
            status_next = ST_OK;
            case (cmd)
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.push_back = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.push_front = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.pop_front = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.pop_back = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    ctl.clear  = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    // peek and spare codes
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // Neighbor wiring; the head sees an always-occupied slot holding the
    // incoming word, the tail sees an empty one.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign prev_data[g] = value;
                assign prev_occ[g]  = 1'b1;
            end
            else
            begin : g_mid_prev
                assign prev_data[g] = data[g-1];
                assign prev_occ[g]  = occ[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign next_data[g] = '0;
                assign next_occ[g]  = 1'b0;
            end
            else
            begin : g_mid_next
                assign next_data[g] = data[g+1];
                assign next_occ[g]  = occ[g+1];
            end

            deq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .value     (value),
                .prev_data (prev_data[g]),
                .prev_occ  (prev_occ[g]),
                .next_data (next_data[g]),
                .next_occ  (next_occ[g]),
                .data      (data[g]),
                .occ       (occ[g])
            );
        end
    endgenerate

    deq_back_sel #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back_sel (
        .occ        (occ),
        .data       (data),
        .back_value (back_value)
    );

    assign out_valid   = (state_reg == S_OUT);
    assign status      = status_reg;
    assign front_value = data[0] & {DATA_WIDTH{occ[0]}};
    assign count       = count_reg;
    assign is_empty    = empty;

    `DEQ_ASSERT(a_occ_contig, $onehot0(occ & ~(occ >> 1)), "occupied cells not contiguous")
    `DEQ_ASSERT(a_cnt_occ, (count_reg == '0) == !occ[0], "count disagrees with head cell")
    `DEQ_ASSERT(a_full_cnt, out_valid && (status == ST_FULL) |-> full, "full status below depth")
    `DEQ_ASSERT_ALWAYS(a_out_blocks_in, out_valid |-> in_stall, "command taken while pending")
    `DEQ_ASSERT(a_row_hold, out_valid && out_stall |=> $stable({occ, count_reg}), "row moved")

endmodule

`default_nettype wire
